### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/sdiw_pkg.sv
// constants and register codes for the sphere indicator weight pipeline
package sdiw_pkg;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = FRAC_W + 1;
    localparam int ADDR_W      = 5;
    localparam int SQ_STEPS    = 32;
    localparam int DIV_STEPS   = 19;

    localparam logic [2:0] REG_CENTRE_X = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y = 3'd1;
    localparam logic [2:0] REG_CENTRE_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_INV_GRID = 3'd4;

    localparam logic [30:0] INV_GRID_RESET = 31'd65536;
    localparam logic [16:0] ONE_W          = 17'd65536;
    localparam logic [17:0] X_SAT          = 18'd196608;
    localparam logic [32:0] A_SAT          = 33'h1_FFFF_FFFF;

    // pipeline stage map
    localparam int ST_MAG   = 0;
    localparam int ST_SQR   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_DIST  = ST_SUM + SQ_STEPS + 1;
    localparam int ST_PROD  = ST_DIST + 1;
    localparam int ST_XQ    = ST_PROD + 1;
    localparam int ST_FRAC  = ST_XQ + 1;
    localparam int ST_OUT   = ST_FRAC + DIV_STEPS + 1;
    localparam int N_STAGES = ST_OUT + 1;
endpackage

### hdl/sphere_diffuse_indicator_weights.sv
// one register per stage from input accept to result valid
// throughput: one item per cycle; a stalled stage holds, empty stages ahead still fill
// depth is set by the 32-step square root and the 19-step tanh divider pipelines
// rst_n is asynchronous active low: clears all valid bits and resets the config registers
// config reset: centre 0, radius 0, reciprocal grid spacing 1.0
module sphere_diffuse_indicator_weights
    import sdiw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // volume_weight[16:0], surface_weight[33:17], zero
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0] rad_reg, igs_reg;
    logic [2:0]  ridx;

    assign ridx   = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= '0;
            igs_reg <= INV_GRID_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                REG_CENTRE_X: cx_reg  <= pwdata;
                REG_CENTRE_Y: cy_reg  <= pwdata;
                REG_CENTRE_Z: cz_reg  <= pwdata;
                REG_RADIUS:   rad_reg <= pwdata[30:0];
                REG_INV_GRID: igs_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_CENTRE_X: prdata = cx_reg;
            REG_CENTRE_Y: prdata = cy_reg;
            REG_CENTRE_Z: prdata = cz_reg;
            REG_RADIUS:   prdata = {1'b0, rad_reg};
            REG_INV_GRID: prdata = {1'b0, igs_reg};
            default:      prdata = '0;
        endcase
    end

    // valid bits and per-stage load enables
    logic [N_STAGES-1:0] v_reg;
    logic [N_STAGES-1:0] en;

    always_comb
    begin
        en[N_STAGES-1] = !v_reg[N_STAGES-1] || m_tready;
        for (int i = N_STAGES - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int i = 1; i < N_STAGES; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[N_STAGES-1];

    // offsets, magnitudes and range shift
    logic [32:0] mag0, mag1, mag2;
    logic [1:0]  sh;
    logic [30:0] m0_reg, m1_reg, m2_reg;
    logic [1:0]  s_reg [ST_MAG:ST_DIST-1];

    function automatic logic [32:0] abs_diff(input logic [31:0] p, input logic [31:0] c);
        logic signed [32:0] d;
        d = $signed({p[31], p}) - $signed({c[31], c});
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    always_comb
    begin
        mag0 = abs_diff(s_tdata[31:0], cx_reg);
        mag1 = abs_diff(s_tdata[63:32], cy_reg);
        mag2 = abs_diff(s_tdata[95:64], cz_reg);
        priority if (mag0[32] || mag1[32] || mag2[32])
            sh = 2'd2;
        else if (mag0[31] || mag1[31] || mag2[31])
            sh = 2'd1;
        else
            sh = 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MAG])
        begin
            m0_reg <= 31'(mag0 >> sh);
            m1_reg <= 31'(mag1 >> sh);
            m2_reg <= 31'(mag2 >> sh);
            s_reg[ST_MAG] <= sh;
        end
    end

    logic [61:0] q0_reg, q1_reg, q2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SQR])
        begin
            q0_reg <= 62'(m0_reg) * 62'(m0_reg);
            q1_reg <= 62'(m1_reg) * 62'(m1_reg);
            q2_reg <= 62'(m2_reg) * 62'(m2_reg);
            s_reg[ST_SQR] <= s_reg[ST_MAG];
        end
    end

    // square root, one result bit per stage
    logic [63:0] sq_n    [0:SQ_STEPS];
    logic [33:0] sq_rem  [0:SQ_STEPS];
    logic [31:0] sq_root [0:SQ_STEPS];

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sq_n[0]    <= 64'(q0_reg) + 64'(q1_reg) + 64'(q2_reg);
            sq_rem[0]  <= '0;
            sq_root[0] <= '0;
            s_reg[ST_SUM] <= s_reg[ST_SQR];
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [35:0] rem_sh;
        logic [35:0] trial;
        assign rem_sh = {sq_rem[k], sq_n[k][63:62]};
        assign trial  = {2'b00, sq_root[k], 2'b01};

        always_ff @(posedge clk)
        begin
            if (en[ST_SUM+1+k])
            begin
                sq_n[k+1] <= {sq_n[k][61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    sq_rem[k+1]  <= 34'(rem_sh - trial);
                    sq_root[k+1] <= {sq_root[k][30:0], 1'b1};
                end
                else
                begin
                    sq_rem[k+1]  <= 34'(rem_sh);
                    sq_root[k+1] <= {sq_root[k][30:0], 1'b0};
                end
                if (ST_SUM + 1 + k < ST_DIST)
                    s_reg[ST_SUM+1+k] <= s_reg[ST_SUM+k];
            end
        end
    end

    // signed distance and scaling
    logic [33:0]        r_full;
    logic signed [34:0] sdist;
    logic [34:0]        dist_mag;
    logic [32:0]        a_reg;
    logic               in_reg [ST_DIST:ST_OUT-1];

    always_comb
    begin
        r_full   = 34'(sq_root[SQ_STEPS]) << s_reg[ST_DIST-1];
        sdist    = $signed({4'b0000, rad_reg}) - $signed({1'b0, r_full});
        dist_mag = sdist[34] ? 35'(-sdist) : 35'(sdist);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIST])
        begin
            a_reg <= (dist_mag > 35'(A_SAT)) ? A_SAT : dist_mag[32:0];
            in_reg[ST_DIST] <= !sdist[34] && (sdist != '0);
        end
    end

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            prod_reg <= 64'(a_reg) * 64'(igs_reg);
            in_reg[ST_PROD] <= in_reg[ST_DIST];
        end
    end

    logic [17:0] xq;
    logic [17:0] xq_reg;
    logic [35:0] xsq_reg;

    assign xq = (prod_reg[63:15] > 49'(X_SAT)) ? X_SAT : prod_reg[32:15];

    always_ff @(posedge clk)
    begin
        if (en[ST_XQ])
        begin
            xq_reg  <= xq;
            xsq_reg <= 36'(xq) * 36'(xq);
            in_reg[ST_XQ] <= in_reg[ST_PROD];
        end
    end

    // tanh(x) = x(27+x^2)/(27+9x^2), quotient one bit per stage
    localparam logic [37:0] K27 = 38'(27) << 32;
    logic [55:0] num;
    logic [40:0] den;
    logic [40:0] dv_rem [0:DIV_STEPS];
    logic [18:0] dv_lo  [0:DIV_STEPS];
    logic [18:0] dv_q   [0:DIV_STEPS];
    logic [40:0] dv_den [0:DIV_STEPS];

    always_comb
    begin
        num = 56'(xq_reg) * 56'(K27 + 38'(xsq_reg));
        den = 41'(K27) + 41'(xsq_reg) * 41'd9;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_FRAC])
        begin
            dv_rem[0] <= 41'(num[54:19]);
            dv_lo[0]  <= num[18:0];
            dv_q[0]   <= '0;
            dv_den[0] <= den;
            in_reg[ST_FRAC] <= in_reg[ST_XQ];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [41:0] rem_sh;
        assign rem_sh = {dv_rem[j], dv_lo[j][18]};

        always_ff @(posedge clk)
        begin
            if (en[ST_FRAC+1+j])
            begin
                dv_lo[j+1]  <= {dv_lo[j][17:0], 1'b0};
                dv_den[j+1] <= dv_den[j];
                if (rem_sh >= {1'b0, dv_den[j]})
                begin
                    dv_rem[j+1] <= 41'(rem_sh - {1'b0, dv_den[j]});
                    dv_q[j+1]   <= {dv_q[j][17:0], 1'b1};
                end
                else
                begin
                    dv_rem[j+1] <= rem_sh[40:0];
                    dv_q[j+1]   <= {dv_q[j][17:0], 1'b0};
                end
                if (ST_FRAC + 1 + j < ST_OUT)
                    in_reg[ST_FRAC+1+j] <= in_reg[ST_FRAC+j];
            end
        end
    end

    // weights
    logic [16:0] tc;
    logic [33:0] tt;
    logic [17:0] vsum;
    logic [16:0] vol_reg, surf_reg;

    always_comb
    begin
        tc   = (dv_q[DIV_STEPS] > 19'(ONE_W)) ? ONE_W : dv_q[DIV_STEPS][16:0];
        tt   = 34'(tc) * 34'(tc);
        vsum = in_reg[ST_OUT-1] ? 18'(ONE_W) + 18'(tc) : 18'(ONE_W) - 18'(tc);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            vol_reg  <= vsum[17:1];
            surf_reg <= ONE_W - tt[32:16];
        end
    end

    assign m_tdata = {6'b000000, surf_reg, vol_reg};
endmodule

### hdl/sdiw_checker.sv
// port-level checks for the sphere indicator weight block, bound to the top level
`include "assert_macros.svh"

module sdiw_checker
    import sdiw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        pready
);
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled item changed")
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_tvalid, "item shown during reset")
    `ASSERT_CLK(a_weight_range, clk, rst_n,
        m_tvalid |-> (m_tdata[16:0] <= ONE_W) && (m_tdata[33:17] <= ONE_W),
        "weight above one")
    `ASSERT_CLK(a_ready_free, clk, rst_n,
        !m_tvalid |-> s_tready && pready, "input blocked with output empty")
endmodule

bind sphere_diffuse_indicator_weights sdiw_checker u_sdiw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
